[rtl/flu_pkg.sv]
package flu_pkg;

  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_NL = 8'h0A;

  // Command queue depth (power of two)
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef enum logic [2:0] {
    PH_START        = 3'd0,
    PH_HEADER       = 3'd1,
    PH_AFTER_HEADER = 3'd2,
    PH_SEQ          = 3'd3,
    PH_SEQ_EOL      = 3'd4,
    PH_ERROR        = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // One queued command: an optional newline, then one result
  typedef struct packed {
    logic       pre_nl;
    logic [7:0] ch;
    kind_e      kind;
  } cmd_t;

endpackage

[rtl/flu_if.sv]
interface flu_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface flu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       last;

  modport source (output valid, output out_byte, output out_kind, output last, input ready);
  modport sink   (input valid, input out_byte, input out_kind, input last, output ready);
endinterface

[rtl/flu_front.sv]
module flu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  flu_in_if.sink        in_i,
  input  logic          q_full_i,
  output logic          push_o,
  output flu_pkg::cmd_t cmd_o
);
  import flu_pkg::*;

  phase_e phase_q, phase_d;
  logic   eol;
  logic   emit;
  logic   accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign eol        = (in_i.data_byte == CH_LF) || (in_i.data_byte == CH_CR);
  assign push_o     = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    emit        = 1'b0;
    cmd_o       = '0;
    cmd_o.ch    = in_i.data_byte;
    cmd_o.kind  = KIND_DATA;
    if (in_i.mode) begin
      emit     = 1'b1;
      phase_d  = PH_START;
      cmd_o.ch = '0;
      unique case (phase_q) inside
        PH_HEADER, PH_AFTER_HEADER: cmd_o.kind = KIND_OK;
        PH_SEQ, PH_SEQ_EOL: begin
          cmd_o.pre_nl = 1'b1;
          cmd_o.kind   = KIND_OK;
        end
        default: cmd_o.kind = KIND_ERR;
      endcase
    end else begin
      unique case (phase_q)
        PH_START: begin
          if (!eol) begin
            if (in_i.data_byte == CH_GT) begin
              emit    = 1'b1;
              phase_d = PH_HEADER;
            end else begin
              phase_d = PH_ERROR;
            end
          end
        end
        PH_HEADER: begin
          emit = 1'b1;
          if (eol) phase_d = PH_AFTER_HEADER;
        end
        PH_AFTER_HEADER: begin
          if (!eol) begin
            emit    = 1'b1;
            phase_d = (in_i.data_byte == CH_GT) ? PH_HEADER : PH_SEQ;
          end
        end
        PH_SEQ: begin
          if (eol) phase_d = PH_SEQ_EOL;
          else     emit    = 1'b1;
        end
        PH_SEQ_EOL: begin
          if (!eol) begin
            emit = 1'b1;
            if (in_i.data_byte == CH_GT) begin
              cmd_o.pre_nl = 1'b1;
              phase_d      = PH_HEADER;
            end else begin
              phase_d = PH_SEQ;
            end
          end
        end
        default: phase_d = PH_ERROR;
      endcase
    end
  end

endmodule

[rtl/flu_queue.sv]
module flu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  flu_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output flu_pkg::cmd_t cmd_o
);
  import flu_pkg::*;

  cmd_t           mem_q [QDepth];
  logic [QAw-1:0] wptr_q, rptr_q;
  logic [QAw:0]   cnt_q;

  assign full_o  = (cnt_q == (QAw+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[rtl/flu_back.sv]
module flu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  flu_pkg::cmd_t cmd_i,
  output logic          pop_o,
  flu_out_if.source     out_o
);
  import flu_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;
  kind_e      kind_q;
  logic       last_q;
  logic       nl_done_q;
  logic       load;
  logic       send_nl;

  // Register may take a new result when empty or being drained
  assign load    = !empty_i && (!valid_q || out_o.ready);
  assign send_nl = cmd_i.pre_nl && !nl_done_q;
  assign pop_o   = load && !send_nl;

  assign out_o.valid    = valid_q;
  assign out_o.out_byte = byte_q;
  assign out_o.out_kind = kind_q;
  assign out_o.last     = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      nl_done_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q   <= 1'b1;
        nl_done_q <= send_nl;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (send_nl) begin
        byte_q <= CH_NL;
        kind_q <= KIND_DATA;
        last_q <= 1'b0;
      end else begin
        byte_q <= cmd_i.ch;
        kind_q <= cmd_i.kind;
        last_q <= 1'b1;
      end
    end
  end

endmodule

[rtl/fasta_line_unwrapper.sv]
// Path: a result is written into the command queue once its input byte is accepted,
// then loaded into the output register; for an item with a newline inserted, the
// newline is loaded first. Throughput: one input byte per cycle while the queue is
// not full; items giving two results are absorbed by the four-entry command queue.
// Reset: asynchronous, active low; clears the phase to start, empties the queue
// and drops any pending result.
module fasta_line_unwrapper (
  input  logic      clk_i,
  input  logic      rst_ni,
  flu_in_if.sink    in_i,
  flu_out_if.source out_o
);
  import flu_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push, pop, full, empty;

  flu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  flu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .cmd_o   (head_cmd)
  );

  flu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
